### sv/tilt_pkg.sv
`default_nettype none

package tilt_pkg;

    // number of cordic rotations, limited by the angle table length
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_LEN      = 24;
    localparam int CORDIC_ITER  = (CORDIC_STEPS > ANG_LEN) ? ANG_LEN : CORDIC_STEPS;

    // square root of (a^2 + b^2) * 65536 gives one root bit per stage
    localparam int SQ_W      = 32;
    localparam int V_W       = 48;
    localparam int ROOT_W    = 24;
    localparam int REM_W     = 26;
    localparam int SQRT_BITS = ROOT_W;

    localparam int XY_W = 27;
    localparam int Z_W  = 25;

    localparam logic [16:0] ANGLE_LIMIT = 17'd23040;

    // lane latency: sqrt stages, cordic stages, rounding stage
    localparam int LANE_LAT = SQRT_BITS + CORDIC_ITER + 1;
    // top adds the squares stage, the sums stage and the output register
    localparam int PIPE_LEN = LANE_LAT + 3;

    // atan(2^-i) in 1/65536 degree
    localparam logic signed [Z_W-1:0] ANG [ANG_LEN] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

endpackage

`default_nettype wire

### sv/tilt_sample_if.sv
`default_nettype none

interface tilt_sample_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (
        output valid,
        output accel_x,
        output accel_y,
        output accel_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  accel_x,
        input  accel_y,
        input  accel_z,
        output ready
    );

endinterface

`default_nettype wire

### sv/tilt_angle_if.sv
`default_nettype none

interface tilt_angle_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [16:0] pitch_error;

    modport source (
        output valid,
        output pitch_angle,
        output roll_angle,
        output pitch_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  pitch_angle,
        input  roll_angle,
        input  pitch_error,
        output ready
    );

endinterface

`default_nettype wire

### sv/accel_tilt_angles_core.sv
`default_nettype none

// channel   | dir | contents
// ----------+-----+--------------------------------------------------------
// sample    | in  | accel_x, accel_y, accel_z (signed 16)
// angle     | out | pitch_angle, roll_angle (signed 16), pitch_error (signed 17)
// cfg       | in  | cfg_wr_en, cfg_wr_data: target_pitch (signed 16)
//
// one request per cycle unless the pipeline holds; the stages in order are
// squares, sums, 24 square-root stages, the cordic stages, rounding, output.
// the whole pipeline holds while the output register is full and not taken,
// so ready follows the output side; a held request is never lost or repeated.
// reset clears the valid bits and sets target_pitch to zero.

module accel_tilt_angles_core
    import tilt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    tilt_sample_if.sink             sample,
    tilt_angle_if.source            angle,
    input  wire logic               cfg_wr_en,
    input  wire logic signed [15:0] cfg_wr_data
);

    logic               adv;
    logic               vld_reg [PIPE_LEN];
    logic signed [15:0] target_reg;

    logic signed [31:0] xx_prod;
    logic signed [31:0] yy_prod;
    logic signed [31:0] zz_prod;

    logic [SQ_W-1:0]    xx_reg;
    logic [SQ_W-1:0]    yy_reg;
    logic [SQ_W-1:0]    zz_reg;
    logic signed [15:0] ax1_reg;
    logic signed [15:0] ay1_reg;

    logic [SQ_W-1:0]    sq_p_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic signed [15:0] ax2_reg;
    logic signed [15:0] ay2_reg;

    logic signed [15:0] pitch_lane;
    logic signed [15:0] roll_lane;

    logic signed [15:0] pitch_reg;
    logic signed [15:0] roll_reg;
    logic signed [16:0] err_reg;

    assign adv          = !vld_reg[PIPE_LEN-1] || angle.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_wr_en)
            target_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_LEN; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= sample.valid;
            for (int s = 1; s < PIPE_LEN; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign xx_prod = sample.accel_x * sample.accel_x;
    assign yy_prod = sample.accel_y * sample.accel_y;
    assign zz_prod = sample.accel_z * sample.accel_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg   <= SQ_W'(xx_prod);
            yy_reg   <= SQ_W'(yy_prod);
            zz_reg   <= SQ_W'(zz_prod);
            ax1_reg  <= sample.accel_x;
            ay1_reg  <= sample.accel_y;

            sq_p_reg <= yy_reg + zz_reg;
            sq_r_reg <= xx_reg + zz_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    tilt_lane u_pitch_lane (
        .clk   (clk),
        .adv   (adv),
        .num   (ax2_reg),
        .sq    (sq_p_reg),
        .angle (pitch_lane)
    );

    tilt_lane u_roll_lane (
        .clk   (clk),
        .adv   (adv),
        .num   (ay2_reg),
        .sq    (sq_r_reg),
        .angle (roll_lane)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= pitch_lane;
            roll_reg  <= roll_lane;
            err_reg   <= {target_reg[15], target_reg} - {pitch_lane[15], pitch_lane};
        end
    end

    assign angle.valid       = vld_reg[PIPE_LEN-1];
    assign angle.pitch_angle = pitch_reg;
    assign angle.roll_angle  = roll_reg;
    assign angle.pitch_error = err_reg;

endmodule

`default_nettype wire

### sv/tilt_lane.sv
`default_nettype none

module tilt_lane
    import tilt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               adv,
    input  wire logic signed [15:0] num,
    input  wire logic [SQ_W-1:0]    sq,
    output logic signed [15:0]      angle
);

    logic [REM_W-1:0]  rem_reg   [SQRT_BITS];
    logic [ROOT_W-1:0] root_reg  [SQRT_BITS];
    logic [V_W-1:0]    v_reg     [SQRT_BITS];
    logic signed [15:0] num_sq_reg [SQRT_BITS];
    logic              zero_sq_reg [SQRT_BITS];

    logic signed [XY_W-1:0] x_reg [CORDIC_ITER];
    logic signed [XY_W-1:0] y_reg [CORDIC_ITER];
    logic signed [Z_W-1:0]  z_reg [CORDIC_ITER];
    logic                   zero_cd_reg [CORDIC_ITER];

    logic signed [15:0] angle_reg;

    // restoring square root, one root bit per stage
    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
        logic [REM_W-1:0]   rem_cur;
        logic [ROOT_W-1:0]  root_cur;
        logic [V_W-1:0]     v_cur;
        logic signed [15:0] num_cur;
        logic               zero_cur;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign v_cur    = {sq, 16'b0};
            assign num_cur  = num;
            assign zero_cur = (num == 16'sd0) && (sq == '0);
        end
        else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign v_cur    = v_reg[k-1];
            assign num_cur  = num_sq_reg[k-1];
            assign zero_cur = zero_sq_reg[k-1];
        end

        assign rem_sh = {rem_cur[REM_W-3:0], v_cur[V_W-1 -: 2]};
        assign trial  = {1'b0, root_cur[ROOT_W-2:0], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]     <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k]    <= {root_cur[ROOT_W-2:0], ge};
                v_reg[k]       <= {v_cur[V_W-3:0], 2'b00};
                num_sq_reg[k]  <= num_cur;
                zero_sq_reg[k] <= zero_cur;
            end
        end
    end

    // cordic vectoring, one rotation per stage
    for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_cordic
        logic signed [XY_W-1:0] x_cur;
        logic signed [XY_W-1:0] y_cur;
        logic signed [Z_W-1:0]  z_cur;
        logic                   zero_cur;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        if (i == 0) begin : g_first
            assign x_cur    = {3'b000, root_reg[SQRT_BITS-1]};
            assign y_cur    = {{3{num_sq_reg[SQRT_BITS-1][15]}},
                               num_sq_reg[SQRT_BITS-1], 8'b0};
            assign z_cur    = '0;
            assign zero_cur = zero_sq_reg[SQRT_BITS-1];
        end
        else begin : g_next
            assign x_cur    = x_reg[i-1];
            assign y_cur    = y_reg[i-1];
            assign z_cur    = z_reg[i-1];
            assign zero_cur = zero_cd_reg[i-1];
        end

        assign xs = x_cur >>> i;
        assign ys = y_cur >>> i;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_cur[XY_W-1])
                begin
                    x_reg[i] <= x_cur + ys;
                    y_reg[i] <= y_cur - xs;
                    z_reg[i] <= z_cur + ANG[i];
                end
                else
                begin
                    x_reg[i] <= x_cur - ys;
                    y_reg[i] <= y_cur + xs;
                    z_reg[i] <= z_cur - ANG[i];
                end
                zero_cd_reg[i] <= zero_cur;
            end
        end
    end

    // round |z| / 256 half away from zero, saturate, restore sign; a zero vector gives zero
    logic signed [Z_W-1:0] z_fin;
    logic                  z_neg;
    logic [Z_W-1:0]        z_mag;
    logic [Z_W-1:0]        z_rnd;
    logic [16:0]           deg_q;
    logic [15:0]           deg_sat;
    logic signed [15:0]    angle_next;

    always_comb
    begin
        z_fin   = z_reg[CORDIC_ITER-1];
        z_neg   = z_fin[Z_W-1];
        z_mag   = z_neg ? Z_W'(-z_fin) : Z_W'(z_fin);
        z_rnd   = z_mag + Z_W'(128);
        deg_q   = z_rnd[Z_W-1:8];
        deg_sat = (deg_q > ANGLE_LIMIT) ? ANGLE_LIMIT[15:0] : deg_q[15:0];
        if (zero_cd_reg[CORDIC_ITER-1])
            angle_next = '0;
        else if (z_neg)
            angle_next = -$signed(deg_sat);
        else
            angle_next = $signed(deg_sat);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

### tb/sv/accel_tilt_angles_core_tb.sv
`default_nettype none

module accel_tilt_angles_core_tb;

    import tilt_pkg::*;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [16:0] err;
    } tilt_result_t;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               known;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } probe_row_t;

    localparam int     ROT_STEPS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam longint ANGLE_CAP    = 23040;
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     PHASE_ITEMS  = 180;
    localparam int     NUM_PROBES   = 22;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // only the zero vector has its answer typed in, the rest go through the predictor
    localparam probe_row_t PROBES [NUM_PROBES] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0, 16'sd0},
        '{16'sd32767,  16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sh8000,   16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sh8000,   16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd0,      16'sh8000,   1'b0, 16'sd0, 16'sd0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, 16'sd0, 16'sd0},
        '{16'sh8000,   16'sd32767,  16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd32767,  16'sh8000,   16'sh8000,   1'b0, 16'sd0, 16'sd0},
        '{16'sd1,      16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{-16'sd1,     16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd1,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd1,      1'b0, 16'sd0, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0, 16'sd0},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, 16'sd0, 16'sd0},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 16'sd0, 16'sd0},
        '{16'sd100,    -16'sd200,   16'sd16384,  1'b0, 16'sd0, 16'sd0},
        '{-16'sd16384, 16'sd16384,  16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{16'sd16384,  16'sd0,      -16'sd16384, 1'b0, 16'sd0, 16'sd0},
        '{16'sh5555,   16'shAAAA,   16'sh7FFE,   1'b0, 16'sd0, 16'sd0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic signed [15:0] cfg_wr_data;

    tilt_sample_if sample_bus();
    tilt_angle_if  angle_bus();

    logic signed [15:0] target_pitch_model;
    tilt_result_t       pending_angles [$];
    int                 mismatches;
    int                 quiet_cycles;
    int                 stall_left;
    logic               rx_free;

    accel_tilt_angles_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_bus),
        .angle       (angle_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r   = 0;
        rem = v;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // atan2(num, |(a, b)|) in 1/256 degree, vectoring rotations on 8 fraction bits
    function automatic logic signed [15:0] tilt_deg(int num, int a, int b);
        longint unsigned sq;
        longint          x;
        longint          y;
        longint          z;
        longint          xo;
        longint          mag;
        int              i;
        sq = longint'(a) * longint'(a) + longint'(b) * longint'(b);
        x  = longint'(floor_root(sq << 16));
        y  = longint'(num) * 256;
        z  = 0;
        if (x == 0 && y == 0)
            return 16'sd0;
        for (i = 0; i < ROT_STEPS; i++)
        begin
            xo = x;
            if (y >= 0)
            begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z = z - ATAN_STEP[i];
            end
        end
        mag = (z < 0) ? -z : z;
        mag = (mag + 128) / 256;
        if (mag > ANGLE_CAP)
            mag = ANGLE_CAP;
        return 16'((z < 0) ? -mag : mag);
    endfunction

    function automatic tilt_result_t predict_angles(logic signed [15:0] ax,
                                                    logic signed [15:0] ay,
                                                    logic signed [15:0] az);
        tilt_result_t r;
        r.pitch = tilt_deg(ax, ay, az);
        r.roll  = tilt_deg(ay, ax, az);
        r.err   = 17'(int'(target_pitch_model) - int'(r.pitch));
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] rand_s16(int lo, int hi);
        return 16'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic logic signed [15:0] corner_s16();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, tilt_result_t want);
        sample_bus.valid   <= 1'b1;
        sample_bus.accel_x <= ax;
        sample_bus.accel_y <= ay;
        sample_bus.accel_z <= az;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        pending_angles.push_back(want);
    endtask

    task automatic sender_pause(logic steady);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 35)
            gap = idle_len();
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_angles();
        while (pending_angles.size() != 0)
            @(posedge clk);
        sample_bus.valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic write_target(logic signed [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en          <= 1'b0;
        target_pitch_model  = value;
    endtask

    task automatic random_burst(int count, logic steady);
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        int                 kind;
        int                 k;
        rx_free <= steady;
        for (k = 0; k < count; k++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
            end
            else if (kind < 57)
            begin
                // tiny vectors, close to the zero vector
                ax = rand_s16(-4, 4);
                ay = rand_s16(-4, 4);
                az = rand_s16(-4, 4);
            end
            else if (kind < 69)
            begin
                ax = rand_s16(-8, 8);
                ay = rand_s16(-8, 8);
                az = rand_s16(-8, 8);
                case ($urandom_range(2))
                    0: ax = 16'($urandom);
                    1: ay = 16'($urandom);
                    default: az = 16'($urandom);
                endcase
            end
            else if (kind < 79)
            begin
                // zero magnitude under one of the angles
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'sd0;
                if ($urandom_range(1))
                    ay = 16'sd0;
                else
                    ax = 16'sd0;
            end
            else if (kind < 88)
            begin
                ax = corner_s16();
                ay = corner_s16();
                az = corner_s16();
            end
            else
            begin
                // resting sensor near one g on z
                ax = rand_s16(-8192, 8192);
                ay = rand_s16(-8192, 8192);
                az = $urandom_range(1) ? rand_s16(12000, 20000) : rand_s16(-20000, -12000);
            end
            send_sample(ax, ay, az, predict_angles(ax, ay, az));
            sender_pause(steady);
        end
        sample_bus.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            angle_bus.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_left > 0)
        begin
            angle_bus.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!rx_free && $urandom_range(99) < 25)
        begin
            angle_bus.ready <= 1'b0;
            stall_left      <= idle_len() - 1;
        end
        else
            angle_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        tilt_result_t want;
        if (rst_n && angle_bus.valid && angle_bus.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t unexpected result: pitch %0d roll %0d error %0d", $time,
                         angle_bus.pitch_angle, angle_bus.roll_angle, angle_bus.pitch_error);
                mismatches++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (angle_bus.pitch_angle !== want.pitch)
                begin
                    $display("%0t pitch_angle expected %0d actual %0d", $time,
                             want.pitch, angle_bus.pitch_angle);
                    mismatches++;
                end
                if (angle_bus.roll_angle !== want.roll)
                begin
                    $display("%0t roll_angle expected %0d actual %0d", $time,
                             want.roll, angle_bus.roll_angle);
                    mismatches++;
                end
                if (angle_bus.pitch_error !== want.err)
                begin
                    $display("%0t pitch_error expected %0d actual %0d", $time,
                             want.err, angle_bus.pitch_error);
                    mismatches++;
                end
            end
        end
    end

    // cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
                   || (angle_bus.valid && angle_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tilt_result_t want;
        int           p;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 16'sd0;
        sample_bus.valid   = 1'b0;
        sample_bus.accel_x = 16'sd0;
        sample_bus.accel_y = 16'sd0;
        sample_bus.accel_z = 16'sd0;
        angle_bus.ready    = 1'b0;
        rx_free            = 1'b0;
        target_pitch_model = 16'sd0;
        mismatches         = 0;
        quiet_cycles       = 0;
        stall_left         = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run on the reset value of the target
        for (p = 0; p < NUM_PROBES; p++)
        begin
            if (PROBES[p].known)
            begin
                want.pitch = PROBES[p].pitch;
                want.roll  = PROBES[p].roll;
                want.err   = 17'(int'(target_pitch_model) - int'(PROBES[p].pitch));
            end
            else
                want = predict_angles(PROBES[p].ax, PROBES[p].ay, PROBES[p].az);
            send_sample(PROBES[p].ax, PROBES[p].ay, PROBES[p].az, want);
            sender_pause(1'b0);
        end
        sample_bus.valid <= 1'b0;

        drain_angles();
        write_target(16'sd23040);
        random_burst(PHASE_ITEMS, 1'b0);
        drain_angles();
        write_target(-16'sd23040);
        random_burst(PHASE_ITEMS, 1'b0);
        drain_angles();
        write_target(16'sh8000);
        random_burst(PHASE_ITEMS, 1'b1);
        drain_angles();
        write_target(16'sd32767);
        random_burst(PHASE_ITEMS, 1'b0);
        drain_angles();
        write_target(16'($urandom));
        random_burst(PHASE_ITEMS, 1'b0);
        drain_angles();
        write_target(16'sd0);
        random_burst(PHASE_ITEMS, 1'b0);

        drain_angles();
        repeat (PIPE_LEN + 8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
